// ===== hdl/swbr_pkg.sv =====
// swbr_pkg: shared types and constants of the sliding-window busy-ratio monitor.
// Used by the interfaces, the arithmetic unit, the top level and the checker.
// Depends on nothing.
package swbr_pkg;

  // Field widths fixed by the request and result formats.
  localparam int OPCODE_W   = 2;
  localparam int TIME_W     = 48;
  localparam int LOAD_W     = 7;
  localparam int MAX_REC_W  = 7;
  localparam int WINDOW_W   = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  // Request opcodes.
  localparam logic [OPCODE_W-1:0] OP_GO_IDLE = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_WAKE    = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_QUERY   = 2'd2;
  // Spare opcode: accepted and ignored.
  localparam logic [OPCODE_W-1:0] OP_UNUSED  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RECORDS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_US   = 2'd1;

  // Register reset values.
  localparam logic [MAX_REC_W-1:0] MAX_RECORDS_RST = 7'd64;
  localparam logic [WINDOW_W-1:0]  WINDOW_US_RST   = 32'd1000000;

  // Largest valid load figure.
  localparam logic [LOAD_W-1:0] LOAD_MAX = 7'd100;

  // Operation of the shared adder.
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

endpackage

// ===== hdl/swbr_if.sv =====
// swbr_if: valid/ready channel interfaces for requests and results.
// Depends on swbr_pkg for the field widths.
interface swbr_req_if;
  logic                          valid;
  logic                          ready;
  logic [swbr_pkg::OPCODE_W-1:0] opcode;
  logic [swbr_pkg::TIME_W-1:0]   time_us;

  modport source (output valid, output opcode, output time_us, input ready);
  modport sink   (input valid, input opcode, input time_us, output ready);
endinterface

interface swbr_resp_if;
  logic                        valid;
  logic                        ready;
  logic [swbr_pkg::LOAD_W-1:0] load_percent;

  modport source (output valid, output load_percent, input ready);
  modport sink   (input valid, input load_percent, output ready);
endinterface

// ===== hdl/swbr_ring.sv =====
// swbr_ring: interval record store, one write and one registered read port.
// Depends on nothing; contents are undefined until written.
module swbr_ring #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 33
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/swbr_alu.sv =====
// swbr_alu: the shared add/subtract unit used by the sequencer's arithmetic steps.
// Depends on swbr_pkg for the operation type.
module swbr_alu #(
  parameter int W = 48
) (
  input  logic [W-1:0]      a,
  input  logic [W-1:0]      b,
  input  swbr_pkg::alu_op_t op,
  output logic [W-1:0]      y,
  output logic              carry
);

  logic [W:0] full;

  // On subtraction the top bit is the borrow, set when b is larger than a.
  always_comb begin
    if (op == swbr_pkg::ALU_SUB) begin
      full = {1'b0, a} - {1'b0, b};
    end else begin
      full = {1'b0, a} + {1'b0, b};
    end
  end

  assign y     = full[W-1:0];
  assign carry = full[W];

endmodule

// ===== hdl/sliding_window_busy_ratio.sv =====
// sliding_window_busy_ratio: busy-share monitor for one worker, top level.
// Depends on swbr_pkg, swbr_if, swbr_ring and swbr_alu.
// Requests arrive on req with an opcode and a microsecond time stamp. A go-idle
// request stores the busy interval since the last wake, a wake-up request the
// idle interval since the last sleep, and a query returns one result on resp:
// the busy share, in percent, of the recorded time plus the interval still
// running, after the oldest records are trimmed while the total exceeds
// window_us. Opcode 3 is accepted and ignored, and leaves req.ready high.
// One request is handled at a time. req.ready is low while a go-idle or wake-up
// request passes its span and push steps, and while a query sums the records
// held, trims the oldest as needed and, unless the total is zero, divides. Its
// duration is set by the record store, read one entry per cycle, and by the
// shared adder, which serves the sums, the trim and a seven-step division. The
// result appears in an output register as ready returns; while the receiver
// stalls the block keeps taking requests, and a later query waits in its last
// step until the earlier result has been taken.
// Reset (rst, synchronous) empties the ring, marks the worker busy, clears both
// time stamps and restores 64 records and one second. Only written records are
// read, so the store needs no clearing pass.
module sliding_window_busy_ratio #(
  parameter int RING_DEPTH    = 64,
  parameter int DURATION_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [swbr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [swbr_pkg::CFG_DATA_W-1:0]  cfg_data,
  swbr_req_if.sink                         req,
  swbr_resp_if.source                      resp
);

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int LIM_W = (CNT_W > swbr_pkg::MAX_REC_W) ? CNT_W : swbr_pkg::MAX_REC_W;
  // Sums of all records plus the running interval.
  localparam int SUM_W = DURATION_BITS + CNT_W;
  // Room for busy times one hundred and for the divisor shifted by six.
  localparam int ACC_W = SUM_W + 7;
  localparam int ALU_W = (ACC_W > swbr_pkg::TIME_W) ? ACC_W : swbr_pkg::TIME_W;
  localparam int REC_W = DURATION_BITS + 1;

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_SPAN      = 4'd1;
  localparam logic [3:0] ST_PUSH      = 4'd2;
  localparam logic [3:0] ST_SUM       = 4'd3;
  localparam logic [3:0] ST_TOTAL     = 4'd4;
  localparam logic [3:0] ST_TRIM_CHK  = 4'd5;
  localparam logic [3:0] ST_TRIM_TOT  = 4'd6;
  localparam logic [3:0] ST_TRIM_BUSY = 4'd7;
  localparam logic [3:0] ST_MUL1      = 4'd8;
  localparam logic [3:0] ST_MUL2      = 4'd9;
  localparam logic [3:0] ST_DIV       = 4'd10;
  localparam logic [3:0] ST_DONE      = 4'd11;

  // Configuration registers.
  logic [swbr_pkg::MAX_REC_W-1:0] max_records;
  logic [swbr_pkg::WINDOW_W-1:0]  window_us;

  // Control state.
  logic [3:0]       state;
  logic [IDX_W-1:0] ring_head;
  logic [CNT_W-1:0] ring_count;
  logic             idle_flag;
  logic [IDX_W-1:0] rd_addr;
  logic [CNT_W-1:0] rd_left;
  logic             rd_pend;
  logic [2:0]       div_step;
  logic             out_valid;

  // Payload registers.
  logic [swbr_pkg::TIME_W-1:0]   last_idle_time;
  logic [swbr_pkg::TIME_W-1:0]   last_wake_time;
  logic [swbr_pkg::OPCODE_W-1:0] op;
  logic [swbr_pkg::TIME_W-1:0]   now;
  logic [DURATION_BITS-1:0]      dur;
  logic [SUM_W-1:0]              busy;
  logic [SUM_W-1:0]              idle;
  logic [SUM_W-1:0]              total;
  logic [ACC_W-1:0]              num;
  logic [swbr_pkg::LOAD_W-1:0]   quot;
  logic [swbr_pkg::LOAD_W-1:0]   out_load;

  // Record store ports.
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [REC_W-1:0] mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic [REC_W-1:0] mem_rdata;
  logic [DURATION_BITS-1:0] rec_dur;
  logic                     rec_idle;

  // Shared adder.
  logic [ALU_W-1:0]  alu_a;
  logic [ALU_W-1:0]  alu_b;
  swbr_pkg::alu_op_t alu_op;
  logic [ALU_W-1:0]  alu_y;
  logic              alu_carry;

  // Helper logic.
  logic [swbr_pkg::TIME_W-1:0] span_raw;
  logic [DURATION_BITS-1:0]    span_sat;
  logic [swbr_pkg::TIME_W-1:0] then_time;
  logic [LIM_W-1:0]            max_ext;
  logic [LIM_W-1:0]            limit;
  logic [CNT_W-1:0]            count_inc;
  logic [IDX_W:0]              slot_sum;
  logic [IDX_W-1:0]            slot;
  logic [IDX_W-1:0]            head_inc;
  logic [IDX_W-1:0]            rd_inc;
  logic                        ring_full;
  logic                        over_limit;
  logic                        trim_go;
  logic                        req_fire;

  assign rec_dur  = mem_rdata[DURATION_BITS-1:0];
  assign rec_idle = mem_rdata[DURATION_BITS];

  assign req.ready         = (state == ST_IDLE);
  assign req_fire          = req.valid && req.ready;
  assign resp.valid        = out_valid;
  assign resp.load_percent = out_load;

  // Configuration writes; an index beyond the list changes nothing.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_records <= swbr_pkg::MAX_RECORDS_RST;
      window_us   <= swbr_pkg::WINDOW_US_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        swbr_pkg::CFG_MAX_RECORDS: max_records <= cfg_data[swbr_pkg::MAX_REC_W-1:0];
        swbr_pkg::CFG_WINDOW_US:   window_us   <= cfg_data[swbr_pkg::WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  // Record limit: zero behaves as one, anything above the ring depth as the depth.
  always_comb begin
    max_ext = LIM_W'(max_records);
    if (max_ext == '0) begin
      limit = LIM_W'(1);
    end else if (max_ext > LIM_W'(RING_DEPTH)) begin
      limit = LIM_W'(RING_DEPTH);
    end else begin
      limit = max_ext;
    end
  end

  // Ring index arithmetic. The depth need not be a power of two, so wrapping
  // is done by compare rather than by masking.
  assign ring_full  = (ring_count == CNT_W'(RING_DEPTH));
  assign count_inc  = ring_count + CNT_W'(1);
  assign over_limit = (LIM_W'(count_inc) > limit);
  assign slot_sum   = {1'b0, ring_head} + (IDX_W + 1)'(ring_count[IDX_W-1:0]);
  assign slot       = (slot_sum >= (IDX_W + 1)'(RING_DEPTH))
                      ? IDX_W'(slot_sum - (IDX_W + 1)'(RING_DEPTH))
                      : slot_sum[IDX_W-1:0];
  assign head_inc   = (ring_head == IDX_W'(RING_DEPTH - 1)) ? '0 : ring_head + IDX_W'(1);
  assign rd_inc     = (rd_addr == IDX_W'(RING_DEPTH - 1)) ? '0 : rd_addr + IDX_W'(1);

  // The start of the interval being measured depends on the request.
  always_comb begin
    case (op)
      swbr_pkg::OP_GO_IDLE: then_time = last_wake_time;
      swbr_pkg::OP_WAKE:    then_time = last_idle_time;
      default:              then_time = idle_flag ? last_idle_time : last_wake_time;
    endcase
  end

  // Durations are the 48-bit modular difference, saturated to the stored width.
  assign span_raw = alu_y[swbr_pkg::TIME_W-1:0];
  assign span_sat = ((span_raw >> DURATION_BITS) != '0) ? '1
                    : span_raw[DURATION_BITS-1:0];

  // The trim step starts when records remain and the total exceeds the window.
  assign trim_go = (ring_count != '0) && alu_carry;

  // Operand selection for the shared adder, one use per sequencer step.
  always_comb begin
    alu_a  = '0;
    alu_b  = '0;
    alu_op = swbr_pkg::ALU_ADD;
    case (state)
      ST_SPAN: begin
        alu_a  = ALU_W'(now);
        alu_b  = ALU_W'(then_time);
        alu_op = swbr_pkg::ALU_SUB;
      end
      ST_SUM: begin
        alu_a = rec_idle ? ALU_W'(idle) : ALU_W'(busy);
        alu_b = ALU_W'(rec_dur);
      end
      ST_TOTAL: begin
        alu_a = ALU_W'(busy);
        alu_b = ALU_W'(idle);
      end
      ST_TRIM_CHK: begin
        alu_a  = ALU_W'(window_us);
        alu_b  = ALU_W'(total);
        alu_op = swbr_pkg::ALU_SUB;
      end
      ST_TRIM_TOT: begin
        alu_a  = ALU_W'(total);
        alu_b  = ALU_W'(rec_dur);
        alu_op = swbr_pkg::ALU_SUB;
      end
      ST_TRIM_BUSY: begin
        alu_a  = ALU_W'(busy);
        alu_b  = ALU_W'(rec_dur);
        alu_op = swbr_pkg::ALU_SUB;
      end
      // One hundred times busy is built as 64 + 32 + 4 times busy.
      ST_MUL1: begin
        alu_a = ALU_W'(ACC_W'(busy) << 6);
        alu_b = ALU_W'(ACC_W'(busy) << 5);
      end
      ST_MUL2: begin
        alu_a = ALU_W'(num);
        alu_b = ALU_W'(ACC_W'(busy) << 2);
      end
      ST_DIV: begin
        alu_a  = ALU_W'(num);
        alu_b  = ALU_W'(ACC_W'(total) << div_step);
        alu_op = swbr_pkg::ALU_SUB;
      end
      default: ;
    endcase
  end

  swbr_alu #(
    .W (ALU_W)
  ) u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .op    (alu_op),
    .y     (alu_y),
    .carry (alu_carry)
  );

  // Record store control.
  always_comb begin
    mem_we    = (state == ST_PUSH);
    mem_waddr = ring_full ? ring_head : slot;
    mem_wdata = {(op == swbr_pkg::OP_WAKE), dur};
    mem_re    = 1'b0;
    mem_raddr = rd_addr;
    if (state == ST_SUM && rd_left != '0) begin
      mem_re = 1'b1;
    end else if (state == ST_TRIM_CHK && trim_go) begin
      mem_re    = 1'b1;
      mem_raddr = ring_head;
    end
  end

  swbr_ring #(
    .DEPTH (RING_DEPTH),
    .WIDTH (REC_W)
  ) u_ring (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      ring_head      <= '0;
      ring_count     <= '0;
      idle_flag      <= 1'b0;
      last_idle_time <= '0;
      last_wake_time <= '0;
      rd_pend        <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      // The last step refills the output register itself when it is taken.
      if (out_valid && resp.ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_fire) begin
            op  <= req.opcode;
            now <= req.time_us;
            if (req.opcode != swbr_pkg::OP_UNUSED) begin
              state <= ST_SPAN;
            end
          end
        end
        ST_SPAN: begin
          dur <= span_sat;
          if (op == swbr_pkg::OP_QUERY) begin
            busy    <= idle_flag ? '0 : SUM_W'(span_sat);
            idle    <= idle_flag ? SUM_W'(span_sat) : '0;
            rd_addr <= ring_head;
            rd_left <= ring_count;
            rd_pend <= 1'b0;
            state   <= ST_SUM;
          end else begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          // A full ring overwrites its oldest record; otherwise append and
          // drop the oldest if the limit is now passed.
          if (ring_full || over_limit) begin
            ring_head <= head_inc;
          end
          if (!ring_full && !over_limit) begin
            ring_count <= count_inc;
          end
          if (op == swbr_pkg::OP_GO_IDLE) begin
            idle_flag      <= 1'b1;
            last_idle_time <= now;
          end else begin
            idle_flag      <= 1'b0;
            last_wake_time <= now;
          end
          state <= ST_IDLE;
        end
        ST_SUM: begin
          if (rd_pend) begin
            if (rec_idle) begin
              idle <= alu_y[SUM_W-1:0];
            end else begin
              busy <= alu_y[SUM_W-1:0];
            end
          end
          if (rd_left != '0) begin
            rd_addr <= rd_inc;
            rd_left <= rd_left - CNT_W'(1);
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            if (!rd_pend) begin
              state <= ST_TOTAL;
            end
          end
        end
        ST_TOTAL: begin
          total <= alu_y[SUM_W-1:0];
          state <= ST_TRIM_CHK;
        end
        ST_TRIM_CHK: begin
          state <= trim_go ? ST_TRIM_TOT : ST_MUL1;
        end
        ST_TRIM_TOT: begin
          total <= alu_y[SUM_W-1:0];
          state <= ST_TRIM_BUSY;
        end
        ST_TRIM_BUSY: begin
          if (!rec_idle) begin
            busy <= alu_y[SUM_W-1:0];
          end
          ring_head  <= head_inc;
          ring_count <= ring_count - CNT_W'(1);
          state      <= ST_TRIM_CHK;
        end
        ST_MUL1: begin
          if (total == '0) begin
            quot  <= '0;
            state <= ST_DONE;
          end else begin
            num   <= alu_y[ACC_W-1:0];
            state <= ST_MUL2;
          end
        end
        ST_MUL2: begin
          num      <= alu_y[ACC_W-1:0];
          quot     <= '0;
          div_step <= 3'd6;
          state    <= ST_DIV;
        end
        ST_DIV: begin
          // Restoring division, one quotient bit per step, top bit first.
          quot <= {quot[swbr_pkg::LOAD_W-2:0], ~alu_carry};
          if (!alu_carry) begin
            num <= alu_y[ACC_W-1:0];
          end
          if (div_step == 3'd0) begin
            state <= ST_DONE;
          end else begin
            div_step <= div_step - 3'd1;
          end
        end
        ST_DONE: begin
          if (!out_valid || resp.ready) begin
            out_valid <= 1'b1;
            out_load  <= quot;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/swbr_checker.sv =====
// swbr_checker: port-level assertions for the busy-ratio monitor, and its bind.
// Depends on swbr_pkg and on the top level's ports.
module swbr_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_valid,
  input logic                            req_ready,
  input logic [swbr_pkg::OPCODE_W-1:0]   req_opcode,
  input logic                            resp_valid,
  input logic                            resp_ready,
  input logic [swbr_pkg::LOAD_W-1:0]     load_percent
);

  // A waiting result stays offered until it is taken.
  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    resp_valid && !resp_ready |=> resp_valid)
    else $error("result request withdrawn while stalled");

  // A waiting result does not change.
  a_resp_stable: assert property (@(posedge clk) disable iff (rst)
    resp_valid && !resp_ready |=> $stable(load_percent))
    else $error("result changed while stalled");

  // The load figure is a percentage.
  a_load_range: assert property (@(posedge clk) disable iff (rst)
    resp_valid |-> load_percent <= swbr_pkg::LOAD_MAX)
    else $error("load above one hundred percent");

  // Reset leaves no result on offer.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !resp_valid)
    else $error("result offered after reset");

  // Every known request keeps the block busy for at least the next cycle.
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_opcode != swbr_pkg::OP_UNUSED) |=> !req_ready)
    else $error("ready held after an accepted request");

endmodule

bind sliding_window_busy_ratio swbr_checker u_swbr_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .req_opcode   (req.opcode),
  .resp_valid   (resp.valid),
  .resp_ready   (resp.ready),
  .load_percent (resp.load_percent)
);
